// ----- hdl/rvd_pkg.sv -----
// shared types, codes and float helpers for the register value decoder
package rvd_pkg;

	typedef enum logic [2:0] {
		VT_U16 = 3'd0,
		VT_I16 = 3'd1,
		VT_U32 = 3'd2,
		VT_I32 = 3'd3,
		VT_F32 = 3'd4
	} vtype_t;

	typedef enum logic [1:0] {
		BO_ABCD = 2'd0,
		BO_BADC = 2'd1,
		BO_CDAB = 2'd2,
		BO_DCBA = 2'd3
	} border_t;

	localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;

	typedef struct packed {
		logic [15:0] reg_first;
		logic [15:0] reg_second;
		logic [2:0]  value_type;
		logic [1:0]  byte_order;
		logic [31:0] scale_bits;
		logic [31:0] offset_bits;
	} req_t;

	typedef struct packed {
		logic [31:0] value_bits;
	} rsp_t;

	// unpacked float: special flags, sign, unbiased exp, significand with hidden bit
	typedef struct packed {
		logic        nan;
		logic        inf;
		logic        zero;
		logic        sign;
		logic signed [9:0] exp;
		logic [23:0] man;
	} fp_t;

	function automatic fp_t fp_unpack(input logic [31:0] b);
		fp_t r;
		r.sign = b[31];
		r.nan  = (b[30:23] == 8'hFF) && (b[22:0] != '0);
		r.inf  = (b[30:23] == 8'hFF) && (b[22:0] == '0);
		r.zero = (b[30:0] == '0);
		if (b[30:23] == 8'h00) begin
			r.exp = -10'sd126;
			r.man = {1'b0, b[22:0]};
		end else begin
			r.exp = $signed({2'b00, b[30:23]}) - 10'sd127;
			r.man = {1'b1, b[22:0]};
		end
		return r;
	endfunction

	function automatic logic [5:0] lzc48(input logic [47:0] v);
		logic [5:0] n;
		logic       hit;
		n = 6'd48;
		hit = 1'b0;
		for (int i = 47; i >= 0; i--) begin
			if (!hit && v[i]) begin
				n = 6'(47 - i);
				hit = 1'b1;
			end
		end
		return n;
	endfunction

	// round a value sig * 2^(e - 47), sig msb at bit 47, plus sticky, to binary32
	function automatic logic [31:0] fp_round(input logic sign, input logic signed [11:0] e,
			input logic [47:0] sig, input logic sticky);
		logic [49:0] m;
		logic [6:0]  sh;
		logic signed [11:0] be;
		logic [23:0] kept;
		logic        g, st;
		logic [24:0] rnd;
		logic [31:0] r;
		be = e + 12'sd127;
		m = {sig, 2'b00};
		st = sticky;
		if (be < 12'sd1) begin
			sh = (be < -12'sd30) ? 7'd32 : 7'(12'sd1 - be);
			for (int i = 0; i < 50; i++) begin
				if (i < int'(sh) && m[i]) st = 1'b1;
			end
			m = m >> sh;
			be = 12'sd0;
		end
		kept = m[49:26];
		g = m[25];
		st = st | (m[24:0] != '0);
		rnd = {1'b0, kept} + 25'(g && (st || kept[0]));
		if (rnd[24]) begin
			rnd = rnd >> 1;
			be = be + 12'sd1;
		end else if (be == 12'sd0 && rnd[23]) begin
			be = 12'sd1;
		end
		if (be >= 12'sd255) r = {sign, 8'hFF, 23'd0};
		else r = {sign, be[7:0], rnd[22:0]};
		return r;
	endfunction

endpackage

// ----- hdl/rvd_if.sv -----
// valid/ready channel carrying one request or result payload
interface rvd_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/rvd_raw.sv -----
// byte arrangement and integer to float conversion, registered
module rvd_raw
	import rvd_pkg::*;
(
	input  logic        clk,
	input  logic        en,
	input  req_t        req,
	output logic [31:0] raw_s1,
	output logic [31:0] scale_s1,
	output logic [31:0] offset_s1
);
	logic [7:0]  b0, b1, b2, b3;
	logic [31:0] word, mag, raw;
	logic        neg;
	logic [47:0] ext;
	logic [5:0]  lz;
	logic [47:0] nrm;

	always_comb begin
		b0 = req.reg_first[15:8];
		b1 = req.reg_first[7:0];
		b2 = req.reg_second[15:8];
		b3 = req.reg_second[7:0];
		case (border_t'(req.byte_order))
			BO_BADC: word = {b1, b0, b3, b2};
			BO_CDAB: word = {b2, b3, b0, b1};
			BO_DCBA: word = {b3, b2, b1, b0};
			default: word = {b0, b1, b2, b3};
		endcase
		neg = 1'b0;
		mag = '0;
		case (req.value_type)
			VT_U16: mag = {16'd0, req.reg_first};
			VT_I16: begin
				neg = req.reg_first[15];
				mag = neg ? {16'd0, 16'(-req.reg_first)} : {16'd0, req.reg_first};
				if (neg && req.reg_first == 16'h8000) mag = 32'h8000;
			end
			VT_U32: mag = word;
			VT_I32: begin
				neg = word[31];
				mag = neg ? -word : word;
			end
			default: mag = '0;
		endcase
		ext = {mag, 16'd0};
		lz = lzc48(ext);
		nrm = ext << lz;
		if (mag == '0) raw = '0;
		else raw = fp_round(neg, 12'sd31 - 12'(lz), nrm, 1'b0);
		if (req.value_type == VT_F32) raw = word;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			raw_s1 <= raw;
			scale_s1 <= req.scale_bits;
			offset_s1 <= req.offset_bits;
		end
	end
endmodule

// ----- hdl/rvd_mul.sv -----
// binary32 multiply, rounded to nearest even, registered
module rvd_mul
	import rvd_pkg::*;
(
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] a,
	input  logic [31:0] b,
	input  logic [31:0] offset_in,
	output logic [31:0] prod_s2,
	output logic [31:0] offset_s2
);
	fp_t         fa, fb;
	logic        sg;
	logic [47:0] p, nrm;
	logic [5:0]  lz;
	logic signed [11:0] e;
	logic [31:0] res;

	always_comb begin
		fa = fp_unpack(a);
		fb = fp_unpack(b);
		sg = fa.sign ^ fb.sign;
		p = fa.man * fb.man;
		lz = lzc48(p);
		nrm = p << lz;
		e = 12'(fa.exp) + 12'(fb.exp) + 12'sd1 - 12'(lz);
		if (fa.nan || fb.nan || (fa.inf && fb.zero) || (fb.inf && fa.zero)) res = CANON_NAN;
		else if (fa.inf || fb.inf) res = {sg, 8'hFF, 23'd0};
		else if (fa.zero || fb.zero) res = {sg, 31'd0};
		else res = fp_round(sg, e, nrm, 1'b0);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2 <= res;
			offset_s2 <= offset_in;
		end
	end
endmodule

// ----- hdl/rvd_add.sv -----
// binary32 add, rounded to nearest even, registered
module rvd_add
	import rvd_pkg::*;
(
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [31:0] sum_s3
);
	fp_t         fa, fb, big, sml;
	logic        swap, sub;
	logic [9:0]  d;
	logic [49:0] mb, ms, sh;
	logic        st;
	logic [50:0] s;
	logic [5:0]  lz;
	logic [47:0] top, nrm;
	logic        st2;
	logic signed [11:0] e;
	logic [31:0] res;

	always_comb begin
		fa = fp_unpack(a);
		fb = fp_unpack(b);
		swap = (fb.exp > fa.exp) || (fb.exp == fa.exp && fb.man > fa.man);
		big = swap ? fb : fa;
		sml = swap ? fa : fb;
		sub = fa.sign ^ fb.sign;
		d = 10'(big.exp - sml.exp);
		mb = {big.man, 26'd0};
		ms = {sml.man, 26'd0};
		st = 1'b0;
		if (d > 10'd49) begin
			st = (ms != '0);
			sh = '0;
		end else begin
			for (int i = 0; i < 50; i++) begin
				if (i < int'(d) && ms[i]) st = 1'b1;
			end
			sh = ms >> d;
		end
		// sticky acts as an extra lsb below the shifted field
		if (sub) s = {1'b0, mb} - {1'b0, sh} - 51'(st);
		else s = {1'b0, mb} + {1'b0, sh};
		top = s[50:3];
		st2 = (s[2:0] != '0) | st;
		lz = lzc48(top);
		nrm = top << lz;
		if (lz != 6'd0) begin
			nrm = 48'((s << lz) >> 3);
			st2 = ((s << lz) & 51'h7) != '0 || st;
		end
		e = 12'(big.exp) + 12'sd1 - 12'(lz);
		if (fa.nan || fb.nan || (fa.inf && fb.inf && sub)) res = CANON_NAN;
		else if (fa.inf) res = a;
		else if (fb.inf) res = b;
		else if (s == '0) res = {fa.sign & fb.sign, 31'd0};
		else res = fp_round(big.sign, e, nrm, st2);
	end

	always_ff @(posedge clk) begin
		if (en) sum_s3 <= res;
	end
endmodule

// ----- hdl/register_value_decoder.sv -----
// top level: register word decode, scale multiply and offset add pipeline
//
//   channel | dir | payload
//   req     | in  | reg_first, reg_second, value_type, byte_order, scale_bits, offset_bits
//   rsp     | out | value_bits
//
// three stages: raw conversion, multiply, add; one request per cycle while rsp is not stalled
// a result passes the raw, multiply and add registers in turn before rsp.valid rises
// a stall on rsp freezes the last stage and every occupied stage whose successor is frozen
// reset clears the stage valid bits only
module register_value_decoder
	import rvd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	rvd_if.sink   req,
	rvd_if.source rsp
);
	logic        v_s1, v_s2, v_s3;
	logic        en1, en2, en3;
	logic [31:0] raw_s1, scale_s1, offset_s1, prod_s2, offset_s2, sum_s3;

	assign en3 = !v_s3 || rsp.ready;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign req.ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) v_s1 <= req.valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
		end
	end

	rvd_raw u_raw (
		.clk(clk), .en(en1 && req.valid), .req(req.data),
		.raw_s1(raw_s1), .scale_s1(scale_s1), .offset_s1(offset_s1)
	);

	rvd_mul u_mul (
		.clk(clk), .en(en2 && v_s1), .a(raw_s1), .b(scale_s1), .offset_in(offset_s1),
		.prod_s2(prod_s2), .offset_s2(offset_s2)
	);

	rvd_add u_add (
		.clk(clk), .en(en3 && v_s2), .a(prod_s2), .b(offset_s2), .sum_s3(sum_s3)
	);

	assign rsp.valid = v_s3;
	assign rsp.data.value_bits = sum_s3;
endmodule
